@@ src/wade_pkg.sv @@
// Shared constants and types of the window edge detector.
package wade_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;

    localparam int PIX_W  = 16;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WREG_W = $clog2(MAX_WIDTH + 1);
    localparam int HREG_W = $clog2(MAX_HEIGHT + 1);
    localparam int THR_W  = 19;
    localparam int DIFF_W = PIX_W;
    localparam int SUM_W  = DIFF_W + 3;
    localparam int TAPS   = 9;
    localparam int CTR    = 4;
    localparam int LINE_W = 2 * PIX_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(655);
    localparam logic [WREG_W-1:0] WIDTH_RESET     = WREG_W'(1024);
    localparam logic [HREG_W-1:0] HEIGHT_RESET    = HREG_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(2);

    typedef logic [TAPS-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic             interior;
        logic             last;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } t_meta;

endpackage

@@ src/wade_if.sv @@
// Stream interfaces of the window edge detector.
interface wade_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [wade_pkg::PIX_W-1:0] sample;
    logic                            frame_start;

    modport source(output valid, output sample, output frame_start, input ready);
    modport sink(input valid, input sample, input frame_start, output ready);
endinterface

interface wade_out_if;
    logic                        valid;
    logic                        ready;
    logic                        edge_res;
    logic [wade_pkg::COL_W-1:0]  column;
    logic [wade_pkg::ROW_W-1:0]  row;
    logic                        last;

    modport source(output valid, output edge_res, output column, output row, output last,
                   input ready);
    modport sink(input valid, input edge_res, input column, input row, input last,
                 output ready);
endinterface

@@ src/wade_line_mem.sv @@
// Two line buffers in one memory word per column, with write-to-read forwarding.
module wade_line_mem (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rd_en,
    input  logic [wade_pkg::COL_W-1:0]       i_rd_addr,
    output logic [wade_pkg::LINE_W-1:0]      o_rd_data,
    input  logic                             i_wr_en,
    input  logic [wade_pkg::COL_W-1:0]       i_wr_addr,
    input  logic [wade_pkg::LINE_W-1:0]      i_wr_data
);

    logic [wade_pkg::LINE_W-1:0] r_mem [wade_pkg::MAX_WIDTH];
    logic [wade_pkg::LINE_W-1:0] r_rd;
    logic [wade_pkg::LINE_W-1:0] r_fwd;
    logic                        r_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd  <= r_mem[i_rd_addr];
            r_fwd <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_hit ? r_fwd : r_rd;

endmodule

@@ src/wade_sad.sv @@
// Absolute differences, their sum and the threshold compare.
module wade_sad (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  wade_pkg::t_win                i_win,
    input  wade_pkg::t_meta               i_meta,
    input  logic [wade_pkg::THR_W-1:0]    i_threshold,
    output logic                          o_valid,
    output logic                          o_edge_res,
    output wade_pkg::t_meta               o_meta
);

    logic [wade_pkg::TAPS-1:0][wade_pkg::DIFF_W-1:0] n_diff;
    logic [wade_pkg::TAPS-1:0][wade_pkg::DIFF_W-1:0] r_diff;
    logic [wade_pkg::SUM_W-1:0]                      n_sum;
    logic [wade_pkg::SUM_W-1:0]                      r_sum;
    logic                                            r_p2_valid;
    logic                                            r_p3_valid;
    wade_pkg::t_meta                                 r_p2_meta;
    wade_pkg::t_meta                                 r_p3_meta;
    logic                                            r_valid;
    logic                                            r_edge;
    wade_pkg::t_meta                                 r_meta;

    always_comb begin
        logic signed [wade_pkg::PIX_W:0] d;
        for (int k = 0; k < wade_pkg::TAPS; k++) begin
            d = $signed({i_win[wade_pkg::CTR][wade_pkg::PIX_W-1], i_win[wade_pkg::CTR]})
              - $signed({i_win[k][wade_pkg::PIX_W-1], i_win[k]});
            n_diff[k] = d[wade_pkg::PIX_W] ? wade_pkg::DIFF_W'(-d) : wade_pkg::DIFF_W'(d);
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < wade_pkg::TAPS; k++) begin
            n_sum = n_sum + wade_pkg::SUM_W'(r_diff[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else if (i_adv) begin
            r_p2_valid <= i_valid;
            r_p3_valid <= r_p2_valid;
            r_valid    <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_diff    <= n_diff;
            r_p2_meta <= i_meta;
            r_sum     <= n_sum;
            r_p3_meta <= r_p2_meta;
            r_edge    <= r_p3_meta.interior && (r_sum > wade_pkg::SUM_W'(i_threshold));
            r_meta    <= r_p3_meta;
        end
    end

    assign o_valid    = r_valid;
    assign o_edge_res = r_edge;
    assign o_meta     = r_meta;

endmodule

@@ src/window_abs_diff_edge_detector_core.sv @@
// Top level of the 3x3 window edge detector.
// A result passes the input, window, difference, sum and output registers in turn.
// Throughput: one pixel per cycle unless stalled; a pixel reads and writes line memory.
// Backpressure holds the whole pipeline; a beat is taken whenever the output can advance.
// Reset clears position counters, window, pipeline valids and loads the register defaults.
// Line memory is not cleared; after a frame start unwritten columns only reach borders.
module window_abs_diff_edge_detector_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wade_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wade_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    wade_in_if.sink                            i_in,
    wade_out_if.source                         o_out
);

    logic [wade_pkg::THR_W-1:0]  r_thr;
    logic [wade_pkg::WREG_W-1:0] r_w;
    logic [wade_pkg::HREG_W-1:0] r_h;
    logic [wade_pkg::COL_W-1:0]  r_col;
    logic [wade_pkg::ROW_W-1:0]  r_row;

    logic                        adv;
    logic                        accept;
    logic [wade_pkg::COL_W-1:0]  x;
    logic [wade_pkg::ROW_W-1:0]  y;
    logic [wade_pkg::WREG_W-1:0] x_inc;
    logic [wade_pkg::HREG_W-1:0] y_inc;
    logic [wade_pkg::COL_W-1:0]  n_col;
    logic [wade_pkg::ROW_W-1:0]  n_row;
    wade_pkg::t_meta             n_meta;
    logic [wade_pkg::WREG_W-1:0] n_w;
    logic [wade_pkg::HREG_W-1:0] n_h;

    logic                        r_p0_valid;
    logic                        r_p0_emit;
    logic [wade_pkg::COL_W-1:0]  r_p0_x;
    logic [wade_pkg::PIX_W-1:0]  r_p0_pix;
    wade_pkg::t_meta             r_p0_meta;
    logic [wade_pkg::LINE_W-1:0] rd_data;
    logic [wade_pkg::PIX_W-1:0]  top_pix;
    logic [wade_pkg::PIX_W-1:0]  mid_pix;
    logic                        wr_en;

    wade_pkg::t_win              r_win;
    logic                        r_p1_valid;
    wade_pkg::t_meta             r_p1_meta;

    logic                        sad_valid;
    logic                        sad_edge;
    wade_pkg::t_meta             sad_meta;

    assign adv      = !sad_valid || o_out.ready;
    assign accept   = i_in.valid && adv;
    assign i_in.ready = adv;

    always_comb begin
        n_w = i_cfg_data[wade_pkg::WREG_W-1:0];
        if (n_w < wade_pkg::WREG_W'(wade_pkg::MIN_DIM)) begin
            n_w = wade_pkg::WREG_W'(wade_pkg::MIN_DIM);
        end else if (n_w > wade_pkg::WREG_W'(wade_pkg::MAX_WIDTH)) begin
            n_w = wade_pkg::WREG_W'(wade_pkg::MAX_WIDTH);
        end
        n_h = i_cfg_data[wade_pkg::HREG_W-1:0];
        if (n_h < wade_pkg::HREG_W'(wade_pkg::MIN_DIM)) begin
            n_h = wade_pkg::HREG_W'(wade_pkg::MIN_DIM);
        end else if (n_h > wade_pkg::HREG_W'(wade_pkg::MAX_HEIGHT)) begin
            n_h = wade_pkg::HREG_W'(wade_pkg::MAX_HEIGHT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= wade_pkg::THRESHOLD_RESET;
            r_w   <= wade_pkg::WIDTH_RESET;
            r_h   <= wade_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wade_pkg::CFG_THRESHOLD: begin
                    r_thr <= i_cfg_data[wade_pkg::THR_W-1:0];
                end
                wade_pkg::CFG_IMAGE_WIDTH: begin
                    r_w <= n_w;
                end
                wade_pkg::CFG_IMAGE_HEIGHT: begin
                    r_h <= n_h;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        x     = i_in.frame_start ? '0 : r_col;
        y     = i_in.frame_start ? '0 : r_row;
        x_inc = wade_pkg::WREG_W'(x) + wade_pkg::WREG_W'(1);
        y_inc = wade_pkg::HREG_W'(y) + wade_pkg::HREG_W'(1);
        if (x_inc >= r_w) begin
            n_col = '0;
            n_row = (y_inc >= r_h) ? '0 : y_inc[wade_pkg::ROW_W-1:0];
        end else begin
            n_col = x_inc[wade_pkg::COL_W-1:0];
            n_row = y;
        end
        n_meta.column   = x - wade_pkg::COL_W'(1);
        n_meta.row      = y - wade_pkg::ROW_W'(1);
        n_meta.interior = (n_meta.column != '0)
                       && (wade_pkg::WREG_W'(n_meta.column) + wade_pkg::WREG_W'(2) <= r_w)
                       && (n_meta.row != '0)
                       && (wade_pkg::HREG_W'(n_meta.row) + wade_pkg::HREG_W'(2) <= r_h);
        n_meta.last     = (x_inc == r_w) && (y_inc == r_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (adv) begin
            r_p0_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p0_x    <= x;
            r_p0_pix  <= i_in.sample;
            r_p0_emit <= (x != '0) && (y != '0);
            r_p0_meta <= n_meta;
        end
    end

    assign wr_en   = adv && r_p0_valid;
    assign top_pix = rd_data[wade_pkg::LINE_W-1:wade_pkg::PIX_W];
    assign mid_pix = rd_data[wade_pkg::PIX_W-1:0];

    wade_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (x),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_p0_x),
        .i_wr_data ({mid_pix, r_p0_pix})
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_p1_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= r_p0_valid && r_p0_emit;
            if (r_p0_valid) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[3*r]     <= r_win[3*r + 1];
                    r_win[3*r + 1] <= r_win[3*r + 2];
                end
                r_win[2] <= top_pix;
                r_win[5] <= mid_pix;
                r_win[8] <= r_p0_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_meta <= r_p0_meta;
        end
    end

    wade_sad u_sad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (r_p1_valid),
        .i_win       (r_win),
        .i_meta      (r_p1_meta),
        .i_threshold (r_thr),
        .o_valid     (sad_valid),
        .o_edge_res  (sad_edge),
        .o_meta      (sad_meta)
    );

    assign o_out.valid    = sad_valid;
    assign o_out.edge_res = sad_edge;
    assign o_out.column   = sad_meta.column;
    assign o_out.row      = sad_meta.row;
    assign o_out.last     = sad_meta.last;

endmodule

@@ src/wade_checker.sv @@
// Port-level checks of the window edge detector, bound to the top level.
module wade_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_out_edge,
    input  logic [wade_pkg::COL_W-1:0]  i_out_column,
    input  logic [wade_pkg::ROW_W-1:0]  i_out_row,
    input  logic                        i_out_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_column)
            && $stable(i_out_row) && $stable(i_out_edge) && $stable(i_out_last))
        else $error("stalled result changed");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input stalled while output free");

    a_edge_not_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_edge |-> i_out_column != '0 && i_out_row != '0)
        else $error("edge flagged on first row or column");

    a_last_not_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_column != '0 && i_out_row != '0)
        else $error("frame end on first row or column");

endmodule

bind window_abs_diff_edge_detector_core wade_checker u_wade_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_edge   (o_out.edge_res),
    .i_out_column (o_out.column),
    .i_out_row    (o_out.row),
    .i_out_last   (o_out.last)
);

@@ bench/testbench.sv @@
// Self-checking bench for the 3x3 window edge detector: directed table, directed phases, then random phases.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DIR_ROWS      = 28;
    localparam int     RANDOM_ITEMS  = 240;
    localparam int     MAX_GAP       = 60;
    localparam int     SETTLE_CYCLES = 10;
    localparam longint LIMIT_NS      = 64'd4 * 2000 * (2 * MAX_GAP + 4) * 12;

    localparam logic [wade_pkg::PIX_W-1:0] S_MIN = 16'h8000;
    localparam logic [wade_pkg::PIX_W-1:0] S_MAX = 16'h7FFF;

    typedef struct packed {
        logic                       edge_res;
        logic [wade_pkg::COL_W-1:0] column;
        logic [wade_pkg::ROW_W-1:0] row;
        logic                       last;
    } t_px_result;

    typedef struct packed {
        logic [wade_pkg::PIX_W-1:0] sample;
        logic                       fs;
        logic                       typed;
        logic                       has_res;
        t_px_result                 res;
    } t_stim_row;

    typedef enum logic [1:0] {SRC_FULL, SRC_SMOOTH, SRC_EXTREME} t_sample_mode;

    localparam t_px_result NO_RES = '0;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [wade_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [wade_pkg::CFG_DATA_W-1:0] cfg_data;

    wade_in_if  pix_in ();
    wade_out_if edge_out ();

    window_abs_diff_edge_detector_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (pix_in),
        .o_out      (edge_out)
    );

    // predictor state
    logic [wade_pkg::THR_W-1:0]  thr_reg = wade_pkg::THRESHOLD_RESET;
    logic [wade_pkg::WREG_W-1:0] wid_reg = wade_pkg::WIDTH_RESET;
    logic [wade_pkg::HREG_W-1:0] hgt_reg = wade_pkg::HEIGHT_RESET;
    logic [wade_pkg::PIX_W-1:0]  upper_line [wade_pkg::MAX_WIDTH];
    logic [wade_pkg::PIX_W-1:0]  middle_line [wade_pkg::MAX_WIDTH];
    logic [wade_pkg::PIX_W-1:0]  win [3][3];
    int unsigned                 col_pos = 0;
    int unsigned                 row_pos = 0;

    t_px_result                  pending_edges [$];
    t_stim_row                   dir_rows [DIR_ROWS];
    int                          fail_count = 0;
    bit                          src_quiet = 1'b0;
    bit                          snk_quiet = 1'b0;
    logic [wade_pkg::PIX_W-1:0]  smooth_base = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < wade_pkg::MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                win[r][c] = '0;
            end
        end
    end

    function automatic int unsigned fit_dim(input int unsigned v, input int unsigned hi);
        if (v < wade_pkg::MIN_DIM) return wade_pkg::MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit sad_step(input logic [wade_pkg::PIX_W-1:0] pix, input bit fs,
                                    output t_px_result res);
        int unsigned                w, h, x, y, cx, cy;
        logic [wade_pkg::PIX_W-1:0] top, mid;
        int                         ctr, d, sum;
        bit                         interior, got;
        w = fit_dim(wid_reg, wade_pkg::MAX_WIDTH);
        h = fit_dim(hgt_reg, wade_pkg::MAX_HEIGHT);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        top = upper_line[x];
        mid = middle_line[x];
        upper_line[x]  = mid;
        middle_line[x] = pix;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix;
        got = 1'b0;
        res = '0;
        if (x >= 1 && y >= 1) begin
            cx = x - 1;
            cy = y - 1;
            interior = cx >= 1 && cx + 2 <= w && cy >= 1 && cy + 2 <= h;
            if (interior) begin
                ctr = int'($signed(win[1][1]));
                sum = 0;
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        d = ctr - int'($signed(win[r][c]));
                        sum += (d < 0) ? -d : d;
                    end
                end
                res.edge_res = sum > int'(thr_reg);
            end
            res.column = wade_pkg::COL_W'(cx);
            res.row    = wade_pkg::ROW_W'(cy);
            res.last   = (x + 1 == w) && (y + 1 == h);
            got = 1'b1;
        end
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : ((y + 1) & 32'hFFF);
        end else begin
            col_pos = (x + 1) & 32'h3FF;
            row_pos = y;
        end
        return got;
    endfunction

    function automatic int idle_len(inout bit quiet);
        int r;
        if ($urandom_range(0, 199) == 0) quiet = !quiet;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, MAX_GAP);
    endfunction

    function automatic logic [wade_pkg::PIX_W-1:0] next_sample(input t_sample_mode mode);
        case (mode)
            SRC_FULL: begin
                return wade_pkg::PIX_W'($urandom);
            end
            SRC_EXTREME: begin
                return $urandom_range(0, 1) ? S_MAX : S_MIN;
            end
            default: begin
                if ($urandom_range(0, 15) == 0) smooth_base = wade_pkg::PIX_W'($urandom);
                return smooth_base + wade_pkg::PIX_W'($urandom_range(0, 255))
                     - wade_pkg::PIX_W'(128);
            end
        endcase
    endfunction

    function automatic void note_fail(input string what);
        fail_count++;
        if (fail_count <= 10) $display("%s", what);
    endfunction

    task automatic check_px();
        t_px_result got, want;
        got = '{edge_out.edge_res, edge_out.column, edge_out.row, edge_out.last};
        if (pending_edges.size() == 0) begin
            note_fail($sformatf("unexpected beat: edge %b col %0d row %0d last %b",
                                got.edge_res, got.column, got.row, got.last));
        end else begin
            want = pending_edges.pop_front();
            if (got !== want) begin
                note_fail($sformatf(
                    "mismatch exp/act: edge %b/%b col %0d/%0d row %0d/%0d last %b/%b",
                    want.edge_res, got.edge_res, want.column, got.column,
                    want.row, got.row, want.last, got.last));
            end
        end
    endtask

    task automatic send_pixel(input logic [wade_pkg::PIX_W-1:0] s, input bit fs,
                              input bit typed, input bit t_has, input t_px_result t_res);
        int         gap;
        bit         got;
        t_px_result res;
        gap = idle_len(src_quiet);
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.sample      <= s;
        pix_in.frame_start <= fs;
        do @(posedge i_clk); while (!pix_in.ready);
        got = sad_step(s, fs, res);
        if (typed) begin
            got = t_has;
            res = t_res;
        end
        if (got) pending_edges.push_back(res);
    endtask

    // drop valid, wait for every beat, then let the pipeline empty
    task automatic settle();
        int adv;
        pix_in.valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        adv = 0;
        while (adv < SETTLE_CYCLES) begin
            @(posedge i_clk);
            if (edge_out.ready) adv++;
        end
    endtask

    task automatic load_regs(input logic [2:0] sel, input logic [wade_pkg::THR_W-1:0] thr,
                             input logic [wade_pkg::WREG_W-1:0] w,
                             input logic [wade_pkg::HREG_W-1:0] h);
        logic [wade_pkg::CFG_IDX_W-1:0]  idx [3];
        logic [wade_pkg::CFG_DATA_W-1:0] val [3];
        idx = '{wade_pkg::CFG_THRESHOLD, wade_pkg::CFG_IMAGE_WIDTH,
                wade_pkg::CFG_IMAGE_HEIGHT};
        val = '{wade_pkg::CFG_DATA_W'(thr), wade_pkg::CFG_DATA_W'(w),
                wade_pkg::CFG_DATA_W'(h)};
        for (int i = 0; i < 3; i++) begin
            if (sel[i]) begin
                cfg_we   <= 1'b1;
                cfg_idx  <= idx[i];
                cfg_data <= val[i];
                @(posedge i_clk);
                if (idx[i] == wade_pkg::CFG_THRESHOLD) begin
                    thr_reg = val[i][wade_pkg::THR_W-1:0];
                end else if (idx[i] == wade_pkg::CFG_IMAGE_WIDTH) begin
                    wid_reg = val[i][wade_pkg::WREG_W-1:0];
                end else begin
                    hgt_reg = val[i][wade_pkg::HREG_W-1:0];
                end
            end
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [2:0] sel, input logic [wade_pkg::THR_W-1:0] thr,
                             input logic [wade_pkg::WREG_W-1:0] w,
                             input logic [wade_pkg::HREG_W-1:0] h,
                             input int n, input t_sample_mode mode, input bit clean);
        int unsigned                old_w;
        bit                         widen, fs;
        logic [wade_pkg::PIX_W-1:0] s;
        settle();
        old_w = fit_dim(wid_reg, wade_pkg::MAX_WIDTH);
        load_regs(sel, thr, w, h);
        // a wider frame must restart so no unwritten column reaches an interior pixel
        widen = fit_dim(wid_reg, wade_pkg::MAX_WIDTH) > old_w;
        for (int k = 0; k < n; k++) begin
            s = next_sample(mode);
            if (k == 0) begin
                fs = clean || widen || ($urandom_range(0, 1) == 1);
            end else if (clean) begin
                fs = 1'b0;
            end else if (col_pos == 0 && row_pos == 0) begin
                fs = $urandom_range(0, 1) == 1;
            end else begin
                fs = $urandom_range(0, 63) == 0;
            end
            send_pixel(s, fs, 1'b0, 1'b0, NO_RES);
        end
    endtask

    initial begin : result_sink
        int stall;
        stall = 0;
        edge_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && edge_out.valid && edge_out.ready) check_px();
            if (stall == 0 && $urandom_range(0, 3) == 0) stall = idle_len(snk_quiet);
            edge_out.ready <= (stall == 0);
            if (stall > 0) stall--;
        end
    end

    initial begin : stimulus
        int                          random_items, n, r;
        logic [wade_pkg::WREG_W-1:0] w;
        logic [wade_pkg::HREG_W-1:0] h;
        logic [wade_pkg::THR_W-1:0]  thr;
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= '0;
        cfg_data           <= '0;
        pix_in.valid       <= 1'b0;
        pix_in.sample      <= '0;
        pix_in.frame_start <= 1'b0;
        dir_rows = '{
            // 3x3 frame, centre at max against min neighbors, reset threshold
            '{S_MIN, 1'b1, 1'b1, 1'b0, NO_RES},
            '{S_MIN, 1'b0, 1'b1, 1'b0, NO_RES},
            '{S_MIN, 1'b0, 1'b1, 1'b0, NO_RES},
            '{S_MIN, 1'b0, 1'b1, 1'b0, NO_RES},
            '{S_MAX, 1'b0, 1'b1, 1'b1, '{1'b0, 10'd0, 12'd0, 1'b0}},
            '{S_MIN, 1'b0, 1'b1, 1'b1, '{1'b0, 10'd1, 12'd0, 1'b0}},
            '{S_MIN, 1'b0, 1'b1, 1'b0, NO_RES},
            '{S_MIN, 1'b0, 1'b1, 1'b1, '{1'b0, 10'd0, 12'd1, 1'b0}},
            '{S_MIN, 1'b0, 1'b1, 1'b1, '{1'b1, 10'd1, 12'd1, 1'b1}},
            // wrap into a new frame without start flag, sum one above threshold
            '{16'd0,  1'b0, 1'b1, 1'b0, NO_RES},
            '{16'd0,  1'b0, 1'b1, 1'b0, NO_RES},
            '{16'd0,  1'b0, 1'b1, 1'b0, NO_RES},
            '{16'd0,  1'b0, 1'b1, 1'b0, NO_RES},
            '{16'd82, 1'b0, 1'b1, 1'b1, '{1'b0, 10'd0, 12'd0, 1'b0}},
            '{16'd0,  1'b0, 1'b1, 1'b1, '{1'b0, 10'd1, 12'd0, 1'b0}},
            '{16'd0,  1'b0, 1'b1, 1'b0, NO_RES},
            '{16'd0,  1'b0, 1'b1, 1'b1, '{1'b0, 10'd0, 12'd1, 1'b0}},
            '{16'd0,  1'b0, 1'b1, 1'b1, '{1'b1, 10'd1, 12'd1, 1'b1}},
            // restart mid-row, sum equal to threshold
            '{S_MAX,    1'b0, 1'b0, 1'b0, NO_RES},
            '{16'hFF9C, 1'b1, 1'b0, 1'b0, NO_RES},
            '{16'hFF9C, 1'b0, 1'b0, 1'b0, NO_RES},
            '{16'hFF9C, 1'b0, 1'b0, 1'b0, NO_RES},
            '{16'hFF9C, 1'b0, 1'b0, 1'b0, NO_RES},
            '{16'hFF9C, 1'b0, 1'b0, 1'b0, NO_RES},
            '{16'hFF9C, 1'b0, 1'b0, 1'b0, NO_RES},
            '{16'hFF9C, 1'b0, 1'b0, 1'b0, NO_RES},
            '{16'hFF9C, 1'b0, 1'b0, 1'b0, NO_RES},
            '{16'hFD0D, 1'b0, 1'b0, 1'b0, NO_RES}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // clamp both sizes up to three, keep the reset threshold
        load_regs(3'b110, '0, wade_pkg::WREG_W'(2), wade_pkg::HREG_W'(0));
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_pixel(dir_rows[i].sample, dir_rows[i].fs, dir_rows[i].typed,
                       dir_rows[i].has_res, dir_rows[i].res);
        end

        // clamp the width to the maximum and cross into the second row
        run_phase(3'b111, '0, wade_pkg::WREG_W'(2047), wade_pkg::HREG_W'(3), 1024 + 16,
                  SRC_SMOOTH, 1'b1);
        run_phase(3'b111, wade_pkg::THR_W'(524287), wade_pkg::WREG_W'(5),
                  wade_pkg::HREG_W'(4), 40, SRC_EXTREME, 1'b1);
        run_phase(3'b111, wade_pkg::THR_W'(524279), wade_pkg::WREG_W'(3),
                  wade_pkg::HREG_W'(8191), 3 * 20, SRC_EXTREME, 1'b1);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70)      w = wade_pkg::WREG_W'($urandom_range(3, 10));
            else if (r < 90) w = wade_pkg::WREG_W'($urandom_range(11, 40));
            else if (r < 95) w = wade_pkg::WREG_W'($urandom_range(0, 2));
            else             w = wade_pkg::WREG_W'($urandom_range(0, 2047));
            r = $urandom_range(0, 99);
            if (r < 70)      h = wade_pkg::HREG_W'($urandom_range(3, 8));
            else if (r < 90) h = wade_pkg::HREG_W'($urandom_range(9, 20));
            else if (r < 95) h = wade_pkg::HREG_W'($urandom_range(0, 2));
            else             h = wade_pkg::HREG_W'($urandom_range(0, 8191));
            r = $urandom_range(0, 99);
            if (r < 40)      thr = wade_pkg::THR_W'($urandom_range(0, 2000));
            else if (r < 70) thr = wade_pkg::THR_W'($urandom_range(2000, 40000));
            else if (r < 85) thr = wade_pkg::THR_W'($urandom);
            else if (r < 90) thr = '0;
            else if (r < 95) thr = '1;
            else             thr = wade_pkg::THRESHOLD_RESET;
            n = fit_dim(w, wade_pkg::MAX_WIDTH) * fit_dim(h, wade_pkg::MAX_HEIGHT)
                * $urandom_range(1, 2) + $urandom_range(0, 15);
            if (n > 200) n = $urandom_range(60, 200);
            run_phase(3'($urandom_range(1, 7)), thr, w, h, n,
                      t_sample_mode'($urandom_range(0, 2)), 1'b0);
            random_items += n;
        end

        settle();
        if (fail_count == 0) begin
            $display("** window_abs_diff_edge_detector_core: PASSED **");
        end else begin
            $display("** window_abs_diff_edge_detector_core: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("** window_abs_diff_edge_detector_core: FAILED **");
        $finish;
    end

endmodule
